FILE: rtl/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and fixed-point helpers for the Boris particle push.
// ----------------------------------------------------------------------------
`default_nettype none

package bpp_pkg;

    localparam int WORD_W           = 32;
    localparam int PROD_W           = 48;
    localparam int NUM_W            = 50;
    localparam int DEN_W            = 50;
    localparam int QUO_W            = 32;
    localparam int REM_W            = DEN_W + QUO_W;
    localparam int DIV_LAT          = QUO_W + 2;
    localparam int FRONT_LAT        = 3;
    localparam int BACK_LAT         = 4;
    localparam int PIPE_LAT         = FRONT_LAT + DIV_LAT + BACK_LAT;
    localparam int SPATIAL_DIMS_DEF = 3;
    localparam int CFG_IDX_W        = 1;
    localparam int DT_W             = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_KICK_FACTOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 1'b1;

    localparam logic signed [WORD_W-1:0] KICK_RESET = 32'sd0;
    localparam logic [DT_W-1:0]          DT_RESET   = 31'd65536;
    localparam logic [DEN_W-1:0]         Q_ONE      = DEN_W'(65536);

    typedef logic signed [WORD_W-1:0] word_t;
    typedef word_t [2:0] wvec_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [NUM_W-1:0] num_t;
    typedef logic [DEN_W-1:0] den_t;

    typedef struct packed {
        wvec_t v0;
        wvec_t e;
        wvec_t b;
        wvec_t x;
    } side_t;

    function automatic word_t sat32(input logic signed [63:0] val);
        word_t res;
        if (val > 64'sd2147483647)
            res = 32'sh7fffffff;
        else if (val < -64'sd2147483648)
            res = 32'sh80000000;
        else
            res = val[WORD_W-1:0];
        return res;
    endfunction

    // Q16.16 product, floored
    function automatic prod_t qmul(input word_t a, input word_t b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return p[63:16];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bpp_front.sv
// ----------------------------------------------------------------------------
// bpp_front
// Field scaling, first half kick, |b|^2 and rotation numerator (3 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire bpp_pkg::wvec_t v,
    input  wire bpp_pkg::wvec_t x,
    input  wire bpp_pkg::wvec_t fe,
    input  wire bpp_pkg::wvec_t fb,
    input  wire bpp_pkg::word_t kick,
    output logic                out_valid,
    output bpp_pkg::num_t [2:0] num,
    output bpp_pkg::den_t       den,
    output bpp_pkg::side_t      side
);

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    bpp_pkg::wvec_t       s1_v_reg, s1_x_reg, s1_e_reg, s1_b_reg;
    bpp_pkg::wvec_t       s1_e_next, s1_b_next;
    bpp_pkg::wvec_t       s2_v0_reg, s2_e_reg, s2_b_reg, s2_x_reg, s2_v0_next;
    bpp_pkg::prod_t [2:0] s2_bb_reg, s2_bb_next;
    bpp_pkg::num_t [2:0]  s3_num_reg, s3_num_next;
    bpp_pkg::den_t        s3_den_reg, s3_den_next;
    bpp_pkg::side_t       s3_side_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        assign s1_e_next[i]  = bpp_pkg::sat32(64'(bpp_pkg::qmul(kick, fe[i])));
        assign s1_b_next[i]  = bpp_pkg::sat32(64'(bpp_pkg::qmul(kick, fb[i])));
        assign s2_v0_next[i] = bpp_pkg::sat32(64'($signed(s1_v_reg[i]))
                                              + 64'($signed(s1_e_reg[i])));
        assign s2_bb_next[i] = bpp_pkg::qmul(s1_b_reg[i], s1_b_reg[i]);
        assign s3_num_next[i] = bpp_pkg::NUM_W'($signed(s2_v0_reg[i]))
            + bpp_pkg::NUM_W'(bpp_pkg::qmul(s2_v0_reg[J], s2_b_reg[K]))
            - bpp_pkg::NUM_W'(bpp_pkg::qmul(s2_v0_reg[K], s2_b_reg[J]));
    end

    assign s3_den_next = bpp_pkg::Q_ONE
                       + bpp_pkg::DEN_W'($unsigned(s2_bb_reg[0]))
                       + bpp_pkg::DEN_W'($unsigned(s2_bb_reg[1]))
                       + bpp_pkg::DEN_W'($unsigned(s2_bb_reg[2]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_v_reg       <= v;
        s1_x_reg       <= x;
        s1_e_reg       <= s1_e_next;
        s1_b_reg       <= s1_b_next;
        s2_v0_reg      <= s2_v0_next;
        s2_bb_reg      <= s2_bb_next;
        s2_e_reg       <= s1_e_reg;
        s2_b_reg       <= s1_b_reg;
        s2_x_reg       <= s1_x_reg;
        s3_num_reg     <= s3_num_next;
        s3_den_reg     <= s3_den_next;
        s3_side_reg.v0 <= s2_v0_reg;
        s3_side_reg.e  <= s2_e_reg;
        s3_side_reg.b  <= s2_b_reg;
        s3_side_reg.x  <= s2_x_reg;
    end

    assign out_valid = s3_valid_reg;
    assign num       = s3_num_reg;
    assign den       = s3_den_reg;
    assign side      = s3_side_reg;

endmodule

`default_nettype wire

FILE: rtl/bpp_div.sv
// ----------------------------------------------------------------------------
// bpp_div
// Pipelined restoring divider: w = sat32(trunc(2*num/den)) in Q16.16,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_div
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire bpp_pkg::num_t num,
    input  wire bpp_pkg::den_t den,
    output logic               out_valid,
    output bpp_pkg::word_t     w
);

    localparam int NS = bpp_pkg::QUO_W;

    logic                        valid_reg [NS+1];
    logic [bpp_pkg::REM_W-1:0]   rem_reg   [NS+1];
    logic [bpp_pkg::QUO_W-1:0]   quo_reg   [NS+1];
    bpp_pkg::den_t               den_reg   [NS+1];
    logic                        neg_reg   [NS+1];
    logic                        ovf_reg   [NS+1];
    logic                        out_valid_reg;
    bpp_pkg::word_t              w_reg, w_next;

    logic                        neg_next, ovf_next;
    logic [bpp_pkg::NUM_W-1:0]   mag;
    logic [bpp_pkg::REM_W-1:0]   dividend;

    assign neg_next = num[bpp_pkg::NUM_W-1];
    assign mag      = neg_next ? $unsigned(-num) : $unsigned(num);
    assign dividend = bpp_pkg::REM_W'(mag) << 17;
    assign ovf_next = dividend >= {den, bpp_pkg::QUO_W'(0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NS; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s <= NS; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
            out_valid_reg <= valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= dividend;
        quo_reg[0] <= '0;
        den_reg[0] <= den;
        neg_reg[0] <= neg_next;
        ovf_reg[0] <= ovf_next;
    end

    for (genvar s = 1; s <= NS; s++)
    begin : g_step
        localparam int J = NS - s;
        logic [bpp_pkg::REM_W-1:0] trial;
        logic                      fit;
        assign trial = bpp_pkg::REM_W'(den_reg[s-1]) << J;
        assign fit   = rem_reg[s-1] >= trial;
        always_ff @(posedge clk)
        begin
            rem_reg[s] <= fit ? rem_reg[s-1] - trial : rem_reg[s-1];
            quo_reg[s] <= quo_reg[s-1] | (bpp_pkg::QUO_W'(fit) << J);
            den_reg[s] <= den_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
        end
    end

    always_comb
    begin
        if (neg_reg[NS])
        begin
            if (ovf_reg[NS] || quo_reg[NS] > 32'h80000000)
                w_next = 32'sh80000000;
            else
                w_next = -$signed(quo_reg[NS]);
        end
        else
        begin
            if (ovf_reg[NS] || quo_reg[NS][bpp_pkg::QUO_W-1])
                w_next = 32'sh7fffffff;
            else
                w_next = $signed(quo_reg[NS]);
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    assign out_valid = out_valid_reg;
    assign w         = w_reg;

endmodule

`default_nettype wire

FILE: rtl/bpp_back.sv
// ----------------------------------------------------------------------------
// bpp_back
// Rotation, second half kick and position advance (4 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_back
#(
    parameter int SPATIAL_DIMS = bpp_pkg::SPATIAL_DIMS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire bpp_pkg::wvec_t            w,
    input  wire bpp_pkg::side_t            side,
    input  wire logic [bpp_pkg::DT_W-1:0]  dt,
    output logic                           out_valid,
    output bpp_pkg::wvec_t                 nv,
    output bpp_pkg::wvec_t                 nx
);

    logic                 a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    bpp_pkg::prod_t [2:0] a_p1_reg, a_p2_reg, a_p1_next, a_p2_next;
    bpp_pkg::wvec_t       a_v0_reg, a_e_reg, a_x_reg;
    bpp_pkg::wvec_t       b_nv_reg, b_x_reg, b_nv_next;
    bpp_pkg::prod_t [2:0] c_t_reg, c_t_next;
    bpp_pkg::wvec_t       c_nv_reg, c_x_reg;
    bpp_pkg::wvec_t       d_nv_reg, d_nx_reg, d_nx_next;
    bpp_pkg::word_t       dt_word;

    assign dt_word = $signed({1'b0, dt});

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        assign a_p1_next[i] = bpp_pkg::qmul(w[J], side.b[K]);
        assign a_p2_next[i] = bpp_pkg::qmul(w[K], side.b[J]);
        assign b_nv_next[i] = bpp_pkg::sat32(64'($signed(a_v0_reg[i]))
                                             + 64'(a_p1_reg[i])
                                             - 64'(a_p2_reg[i])
                                             + 64'($signed(a_e_reg[i])));
        assign c_t_next[i]  = bpp_pkg::qmul(dt_word, b_nv_reg[i]);
        if (i < SPATIAL_DIMS)
        begin : g_move
            assign d_nx_next[i] = bpp_pkg::sat32(64'($signed(c_x_reg[i]))
                                                 + 64'(c_t_reg[i]));
        end
        else
        begin : g_hold
            assign d_nx_next[i] = c_x_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_p1_reg <= a_p1_next;
        a_p2_reg <= a_p2_next;
        a_v0_reg <= side.v0;
        a_e_reg  <= side.e;
        a_x_reg  <= side.x;
        b_nv_reg <= b_nv_next;
        b_x_reg  <= a_x_reg;
        c_t_reg  <= c_t_next;
        c_nv_reg <= b_nv_reg;
        c_x_reg  <= b_x_reg;
        d_nv_reg <= c_nv_reg;
        d_nx_reg <= d_nx_next;
    end

    assign out_valid = d_valid_reg;
    assign nv        = d_nv_reg;
    assign nx        = d_nx_reg;

endmodule

`default_nettype wire

FILE: rtl/boris_particle_push.sv
// ----------------------------------------------------------------------------
// boris_particle_push
// Boris push of one particle per clock: half electric kick, magnetic rotation,
// second half kick and position advance, signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// A particle is taken on every clock edge where start is high; busy is never
// raised. Its result appears on the new_* ports for one cycle with done high,
// after passing through 3 stages of field scaling and numerator, 34 in the
// bit-per-stage divider by 1+|b|^2, and 4 of rotation and position update.
// Results cannot be held off. Write kick_factor and time_step only while no
// transaction is in flight.
`default_nettype none

module boris_particle_push
#(
    parameter int SPATIAL_DIMS = bpp_pkg::SPATIAL_DIMS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cfg_we,
    input  wire logic [bpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bpp_pkg::WORD_W-1:0]    cfg_wdata,
    input  wire logic signed [31:0]            vel_x,
    input  wire logic signed [31:0]            vel_y,
    input  wire logic signed [31:0]            vel_z,
    input  wire logic signed [31:0]            pos_x,
    input  wire logic signed [31:0]            pos_y,
    input  wire logic signed [31:0]            pos_z,
    input  wire logic signed [31:0]            field_e_x,
    input  wire logic signed [31:0]            field_e_y,
    input  wire logic signed [31:0]            field_e_z,
    input  wire logic signed [31:0]            field_b_x,
    input  wire logic signed [31:0]            field_b_y,
    input  wire logic signed [31:0]            field_b_z,
    output logic                               done,
    output logic signed [31:0]                 new_vel_x,
    output logic signed [31:0]                 new_vel_y,
    output logic signed [31:0]                 new_vel_z,
    output logic signed [31:0]                 new_pos_x,
    output logic signed [31:0]                 new_pos_y,
    output logic signed [31:0]                 new_pos_z
);

    bpp_pkg::word_t              kick_reg;
    logic [bpp_pkg::DT_W-1:0]    dt_reg;

    logic                        accept;
    bpp_pkg::wvec_t              in_v, in_x, in_e, in_b;
    logic                        front_valid;
    bpp_pkg::num_t [2:0]         front_num;
    bpp_pkg::den_t               front_den;
    bpp_pkg::side_t              front_side;
    logic [2:0]                  div_valid;
    bpp_pkg::wvec_t              div_w;
    bpp_pkg::side_t              side_pipe_reg [bpp_pkg::DIV_LAT];
    bpp_pkg::wvec_t              out_v, out_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_reg <= bpp_pkg::KICK_RESET;
            dt_reg   <= bpp_pkg::DT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpp_pkg::CFG_KICK_FACTOR: kick_reg <= $signed(cfg_wdata);
                bpp_pkg::CFG_TIME_STEP:   dt_reg   <= cfg_wdata[bpp_pkg::DT_W-1:0];
                default:                  ;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_v = {vel_z, vel_y, vel_x};
    assign in_x = {pos_z, pos_y, pos_x};
    assign in_e = {field_e_z, field_e_y, field_e_x};
    assign in_b = {field_b_z, field_b_y, field_b_x};

    bpp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .v         (in_v),
        .x         (in_x),
        .fe        (in_e),
        .fb        (in_b),
        .kick      (kick_reg),
        .out_valid (front_valid),
        .num       (front_num),
        .den       (front_den),
        .side      (front_side)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        bpp_div u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (front_valid),
            .num       (front_num[i]),
            .den       (front_den),
            .out_valid (div_valid[i]),
            .w         (div_w[i])
        );
    end

    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= front_side;
        for (int s = 1; s < bpp_pkg::DIV_LAT; s++)
        begin
            side_pipe_reg[s] <= side_pipe_reg[s-1];
        end
    end

    bpp_back #(.SPATIAL_DIMS(SPATIAL_DIMS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[0]),
        .w         (div_w),
        .side      (side_pipe_reg[bpp_pkg::DIV_LAT-1]),
        .dt        (dt_reg),
        .out_valid (done),
        .nv        (out_v),
        .nx        (out_x)
    );

    assign new_vel_x = out_v[0];
    assign new_vel_y = out_v[1];
    assign new_vel_z = out_v[2];
    assign new_pos_x = out_x[0];
    assign new_pos_y = out_x[1];
    assign new_pos_z = out_x[2];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, bpp_pkg::PIPE_LAT))
        else $error("result without matching transaction");

    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[0] == div_valid[1] && div_valid[1] == div_valid[2])
        else $error("divider lanes out of step");

    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid[0] |-> $past(front_valid, bpp_pkg::DIV_LAT))
        else $error("divider output without entry");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

endmodule

`default_nettype wire

FILE: dv/tb_boris_particle_push.sv
// ----------------------------------------------------------------------------
// tb_boris_particle_push
// Self-checking bench for the Boris particle push: a queue-fed driver applies
// particles with random gaps, a predictor computes the pushed velocity and
// position in fixed point, and a monitor compares each done transaction with
// the oldest prediction. Kick factor and time step are swept between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_boris_particle_push;
    import bpp_pkg::*;

    typedef logic signed [31:0] q16_t;

    typedef struct {
        q16_t vel [3];
        q16_t pos [3];
        q16_t fe [3];
        q16_t fb [3];
    } particle_t;

    typedef struct {
        q16_t vel [3];
        q16_t pos [3];
    } pushed_t;

    localparam int TAIL_CYCLES = PIPE_LAT + 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_KICK_FACTOR;
    logic [WORD_W-1:0] cfg_wdata = '0;
    q16_t vel_x = '0, vel_y = '0, vel_z = '0;
    q16_t pos_x = '0, pos_y = '0, pos_z = '0;
    q16_t field_e_x = '0, field_e_y = '0, field_e_z = '0;
    q16_t field_b_x = '0, field_b_y = '0, field_b_z = '0;
    logic done;
    q16_t new_vel_x, new_vel_y, new_vel_z, new_pos_x, new_pos_y, new_pos_z;

    particle_t pending_particles [$];
    pushed_t expected_pushes [$];
    logic signed [63:0] kick_q = 0;
    logic signed [63:0] dt_q = 65536;
    int failures = 0;
    bit quiet_stretch = 1'b0;

    boris_particle_push dut (.*);

    always #5 clk = ~clk;

    function automatic logic signed [63:0] fmul(logic signed [63:0] a,
                                                logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic logic signed [63:0] clip(logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic signed [63:0] rot_div(logic signed [63:0] num,
                                                   logic signed [63:0] den);
        logic [63:0] a, d, qi, r, mag;
        logic neg;
        neg = num < 0;
        a = neg ? -num : num;
        d = den;
        a = a << 1;
        qi = a / d;
        r = a % d;
        mag = (qi << 16) + ((r << 16) / d);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic pushed_t boris_push(particle_t p);
        logic signed [63:0] e [3], b [3], v0 [3], w [3], v1 [3], den;
        pushed_t r;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = clip(fmul(kick_q, p.fe[i]));
            b[i] = clip(fmul(kick_q, p.fb[i]));
            v0[i] = clip(64'(p.vel[i]) + e[i]);
        end
        den = 65536 + fmul(b[0], b[0]) + fmul(b[1], b[1]) + fmul(b[2], b[2]);
        w[0] = clip(rot_div(v0[0] + fmul(v0[1], b[2]) - fmul(v0[2], b[1]), den));
        w[1] = clip(rot_div(v0[1] + fmul(v0[2], b[0]) - fmul(v0[0], b[2]), den));
        w[2] = clip(rot_div(v0[2] + fmul(v0[0], b[1]) - fmul(v0[1], b[0]), den));
        v1[0] = v0[0] + fmul(w[1], b[2]) - fmul(w[2], b[1]);
        v1[1] = v0[1] + fmul(w[2], b[0]) - fmul(w[0], b[2]);
        v1[2] = v0[2] + fmul(w[0], b[1]) - fmul(w[1], b[0]);
        for (int i = 0; i < 3; i++)
        begin
            r.vel[i] = q16_t'(clip(v1[i] + e[i]));
            if (i < SPATIAL_DIMS_DEF)
                r.pos[i] = q16_t'(clip(64'(p.pos[i]) + fmul(dt_q, 64'(r.vel[i]))));
            else
                r.pos[i] = p.pos[i];
        end
        return r;
    endfunction

    // driver
    always @(negedge clk)
    begin
        particle_t p;
        if (rst_n && !busy && pending_particles.size() > 0
            && (quiet_stretch || $urandom_range(99) >= 31))
        begin
            p = pending_particles.pop_front();
            expected_pushes.insert(expected_pushes.size(), boris_push(p));
            start <= 1'b1;
            {vel_x, vel_y, vel_z} <= {p.vel[0], p.vel[1], p.vel[2]};
            {pos_x, pos_y, pos_z} <= {p.pos[0], p.pos[1], p.pos[2]};
            {field_e_x, field_e_y, field_e_z} <= {p.fe[0], p.fe[1], p.fe[2]};
            {field_b_x, field_b_y, field_b_z} <= {p.fb[0], p.fb[1], p.fb[2]};
        end
        else if (!(start && busy))
            start <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        pushed_t x, got;
        if (rst_n && done)
        begin
            got.vel = '{new_vel_x, new_vel_y, new_vel_z};
            got.pos = '{new_pos_x, new_pos_y, new_pos_z};
            if (expected_pushes.size() == 0)
            begin
                $error("unexpected transaction");
                failures++;
            end
            else
            begin
                x = expected_pushes.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (got.vel[i] !== x.vel[i])
                    begin
                        $error("new_vel[%0d] exp %h got %h", i, x.vel[i], got.vel[i]);
                        failures++;
                    end
                    if (got.pos[i] !== x.pos[i])
                    begin
                        $error("new_pos[%0d] exp %h got %h", i, x.pos[i], got.pos[i]);
                        failures++;
                    end
                end
            end
        end
    end

    function automatic q16_t rand_word(int mode);
        case (mode)
            0: return q16_t'($urandom);
            1: return q16_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return q16_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    task automatic add_particle(q16_t v, q16_t x, q16_t fe, q16_t fb);
        particle_t p;
        p.vel = '{v, v, v};
        p.pos = '{x, x, x};
        p.fe = '{fe, fe, fe};
        p.fb = '{fb, fb, fb};
        pending_particles.insert(pending_particles.size(), p);
    endtask

    task automatic add_random(int count);
        particle_t p;
        int m;
        repeat (count)
        begin
            m = $urandom_range(2);
            for (int i = 0; i < 3; i++)
            begin
                p.vel[i] = rand_word(m);
                p.pos[i] = rand_word($urandom_range(2));
                p.fe[i] = rand_word(m);
                p.fb[i] = rand_word(m);
            end
            pending_particles.insert(pending_particles.size(), p);
        end
    endtask

    task automatic drain();
        wait (pending_particles.size() == 0 && expected_pushes.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KICK_FACTOR)
            kick_q = $signed(val);
        else
            dt_q = {33'd0, val[DT_W-1:0]};
    endtask

    initial
    begin
        logic [WORD_W-1:0] kicks [6];
        logic [WORD_W-1:0] steps [6];
        kicks = '{32'h0000_8000, 32'h8000_0000, 32'h7fff_ffff,
                  32'hffff_c000, 32'h0001_0000, 32'h0000_0000};
        steps = '{32'h8000_4000, 32'h7fff_ffff, 32'h0000_0000,
                  32'h0000_0100, 32'h0001_0000, 32'h0002_0000};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: kick zero, pure drift
        add_particle(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        add_particle(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        add_random(4);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_KICK_FACTOR, kicks[ph]);
            write_reg(CFG_TIME_STEP, steps[ph]);
            add_particle(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
            add_particle(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
            add_particle(32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0001_0000);
            add_particle(32'shffff_ffff, 32'sh1, 32'sh0000_ffff, 32'sh8000_0000);
            quiet_stretch = (ph == 3);
            add_random(72);
            drain();
        end

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
